FILE: hw/rtl/bhist_pkg.sv
package bhist_pkg;

  // field widths
  localparam int DATA_W    = 32;
  localparam int SUM_W     = 48;
  localparam int BKT_W     = 4;

  // bounds and buckets
  localparam int NUM_REGS    = 8;
  localparam int NUM_BOUNDS  = 8;
  localparam int NUM_BUCKETS = 9;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int CFG_IDX_W   = 4;

  localparam logic [BKT_W-1:0] OVF_BUCKET = 4'd8;

  // operation codes carried in the input tuser
  localparam logic FUNC_OBSERVE = 1'b0;
  localparam logic FUNC_READ    = 1'b1;

  // stream word widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 152;

  typedef logic [NUM_REGS-1:0][DATA_W-1:0]    bound_vec_t;
  typedef logic [NUM_BUCKETS-1:0][DATA_W-1:0] cnt_vec_t;

  localparam bound_vec_t BOUND_RESET = {
    32'd5000000, 32'd1000000, 32'd500000, 32'd100000,
    32'd50000,   32'd10000,   32'd5000,   32'd1000
  };

  // per-word command from the datapath to the counter bank
  typedef struct packed {
    logic             obs;   // observe word advancing this cycle
    logic [BKT_W-1:0] hit;   // bucket chosen for the sample
    logic [BKT_W-1:0] sel;   // bucket to read, already clamped
  } upd_t;

endpackage

FILE: hw/rtl/bhist_bucket_sel.sv
module bhist_bucket_sel (
  input  logic [bhist_pkg::DATA_W-1:0] sample,
  input  bhist_pkg::bound_vec_t        bounds,
  output logic [bhist_pkg::BKT_W-1:0]  hit
);
  import bhist_pkg::*;

  // parallel compares, lowest-numbered matching bound wins
  always_comb begin
    hit = OVF_BUCKET;
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (sample <= bounds[i]) begin
        hit = BKT_W'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/bhist_counters.sv
module bhist_counters (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bhist_pkg::upd_t              upd,
  input  logic [bhist_pkg::DATA_W-1:0] sample,
  output logic [bhist_pkg::DATA_W-1:0] rd_count,
  output logic [bhist_pkg::DATA_W-1:0] rd_cum,
  output logic [bhist_pkg::DATA_W-1:0] total_nxt,
  output logic [bhist_pkg::SUM_W-1:0]  sum_nxt
);
  import bhist_pkg::*;

  // bucket counters and saturated prefix sums of them
  cnt_vec_t                cnt_r, cnt_nxt;
  cnt_vec_t                pre_r, pre_nxt;
  logic [DATA_W-1:0]       total_r;
  logic [SUM_W-1:0]        sum_r;
  logic [NUM_BUCKETS-1:0]  hit_oh;
  logic [NUM_BUCKETS-1:0]  cnt_full;
  logic                    cnt_bump;
  logic [SUM_W:0]          sum_wide;

  // Prefix k holds min(sum of counters 0..k, max). A real count added to
  // bucket h raises every true prefix at or above h by one, so each prefix
  // only needs a saturating increment.
  always_comb begin
    cnt_nxt = cnt_r;
    pre_nxt = pre_r;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      hit_oh[i]   = (upd.hit == BKT_W'(i));
      cnt_full[i] = &cnt_r[i];
    end
    cnt_bump = upd.obs && !(|(hit_oh & cnt_full));
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (cnt_bump && hit_oh[i]) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
      if (cnt_bump && (BKT_W'(i) >= upd.hit) && !(&pre_r[i])) begin
        pre_nxt[i] = pre_r[i] + 1'b1;
      end
    end
  end

  // total count and running sum, both saturating
  always_comb begin
    total_nxt = total_r;
    sum_nxt   = sum_r;
    sum_wide  = {1'b0, sum_r} + (SUM_W + 1)'(sample);
    if (upd.obs) begin
      if (!(&total_r)) begin
        total_nxt = total_r + 1'b1;
      end
      sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  // read port for the current word
  assign rd_count = cnt_r[upd.sel];
  assign rd_cum   = pre_r[upd.sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      pre_r   <= '0;
      total_r <= '0;
      sum_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      pre_r   <= pre_nxt;
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // first prefix is just bucket 0
  a_pre0: assert property (@(posedge clk) disable iff (!rst_n)
    pre_r[0] == cnt_r[0])
    else $error("prefix of bucket 0 differs from its counter");

  // counts lost to bucket saturation can only lower the full prefix
  a_pre_total: assert property (@(posedge clk) disable iff (!rst_n)
    pre_r[NUM_BUCKETS-1] <= total_r)
    else $error("full prefix exceeds total count");

  // an observe raises an unsaturated total by exactly one
  a_total_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.obs && !(&total_r)) |=> (total_r == $past(total_r) + 32'd1))
    else $error("total count did not advance on observe");

endmodule

FILE: hw/rtl/bucketed_latency_histogram.sv
// Latency histogram over eight software-set ascending bounds plus an overflow
// bucket. One word is accepted and one result can leave per clock with no
// bubbles while out_tready is high: an input register holds the word, a single
// pass of parallel bound compares, a saturating counter bank with running
// prefix sums and the sum adder produces the result, and a result register
// loads it as the word leaves the input register. Each result reflects every
// earlier word, so a read right after an observe already sees it. in_tuser
// selects observe (0) or read (1). Bounds are written through the cfg port
// only while the block is idle, a user rule the block does not enforce;
// writes to index 8 and above are dropped. All counters clear at reset.
module bucketed_latency_histogram (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // config write port
  input  logic                                  cfg_wr_en,
  input  logic [bhist_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bhist_pkg::DATA_W-1:0]          cfg_wdata,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // sample_value[31:0], bucket_select[35:32], zero pad
  input  logic [bhist_pkg::IN_TDATA_W-1:0]      in_tdata,
  // func[0]
  input  logic                                  in_tuser,
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // bucket_hit[3:0], bucket_count[35:4], cumulative_count[67:36],
  // total_count[99:68], value_sum[147:100], zero pad
  output logic [bhist_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import bhist_pkg::*;

  bound_vec_t          bounds_r;

  // input register
  logic                s1_v_r;
  logic                s1_func_r;
  logic [DATA_W-1:0]   s1_sample_r;
  logic [BKT_W-1:0]    s1_sel_r;

  // result register
  logic                out_v_r;
  logic [BKT_W-1:0]    out_hit_r;
  logic [DATA_W-1:0]   out_count_r;
  logic [DATA_W-1:0]   out_cum_r;
  logic [DATA_W-1:0]   out_total_r;
  logic [SUM_W-1:0]    out_sum_r;

  logic                adv;
  logic                in_acc;
  logic                is_obs;
  logic [BKT_W-1:0]    hit;
  logic [BKT_W-1:0]    sel_clamp;
  upd_t                upd;
  logic [DATA_W-1:0]   rd_count;
  logic [DATA_W-1:0]   rd_cum;
  logic [DATA_W-1:0]   total_nxt;
  logic [SUM_W-1:0]    sum_nxt;

  // handshake: word moves on when the result register is free or draining
  assign adv       = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r <= BOUND_RESET;
    end else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      bounds_r[cfg_index[REG_IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r   <= in_tuser;
      s1_sample_r <= in_tdata[DATA_W-1:0];
      s1_sel_r    <= in_tdata[DATA_W+BKT_W-1:DATA_W];
    end
  end

  // select past the overflow bucket reads the overflow bucket
  always_comb begin
    sel_clamp = s1_sel_r;
    if (s1_sel_r inside {[4'd9:4'd15]}) begin
      sel_clamp = OVF_BUCKET;
    end
  end

  assign is_obs = (s1_func_r == FUNC_OBSERVE);

  bhist_bucket_sel u_sel (
    .sample (s1_sample_r),
    .bounds (bounds_r),
    .hit    (hit)
  );

  always_comb begin
    upd.obs = adv && is_obs;
    upd.hit = hit;
    upd.sel = sel_clamp;
  end

  bhist_counters u_cnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .sample    (s1_sample_r),
    .rd_count  (rd_count),
    .rd_cum    (rd_cum),
    .total_nxt (total_nxt),
    .sum_nxt   (sum_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r   <= is_obs ? hit : '0;
      out_count_r <= is_obs ? '0 : rd_count;
      out_cum_r   <= is_obs ? '0 : rd_cum;
      out_total_r <= total_nxt;
      out_sum_r   <= sum_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, out_sum_r, out_total_r, out_cum_r, out_count_r, out_hit_r};

endmodule

FILE: bench/bucketed_latency_histogram_tb.sv
module bucketed_latency_histogram_tb;
  import bhist_pkg::*;

  localparam int CLK_HALF  = 10;
  localparam int RST_CYC   = 5;
  localparam int PIPE_PAD  = 4;        // cycles past the last result before idle
  localparam int CYC_LIMIT = 1000000;
  localparam int MAX_PRINT = 40;
  localparam int HOLD_CYC  = 300;      // long receiver hold-off

  // one expected result word
  typedef struct packed {
    logic [BKT_W-1:0]  hit;
    logic [DATA_W-1:0] cnt;
    logic [DATA_W-1:0] cum;
    logic [DATA_W-1:0] tot;
    logic [SUM_W-1:0]  sum;
  } hist_result_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tuser  = FUNC_OBSERVE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // shadow copy of the block's bounds and counters
  logic [DATA_W-1:0] bound_regs [NUM_REGS];
  logic [DATA_W-1:0] bin_counts [NUM_BUCKETS];
  logic [DATA_W-1:0] obs_total;
  logic [SUM_W-1:0]  lat_sum;

  hist_result_t pending_results [$];
  int           err_count  = 0;
  int           cycle_cnt  = 0;
  bit           hold_req   = 1'b0;   // asks the receiver for one long hold-off
  bit           quiet      = 1'b0;
  int           gap_odds   = 4;   // sender gap on one word in gap_odds; 0 = none

  bucketed_latency_histogram dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // histogram predictor: updates the shadow state and returns the result word
  function automatic hist_result_t histogram_predict(logic op, logic [DATA_W-1:0] smp,
                                                     logic [BKT_W-1:0] sel);
    hist_result_t     r;
    logic [BKT_W-1:0] bin;
    logic [DATA_W:0]  acc;
    logic [SUM_W:0]   wide_sum;
    r = '0;
    if (op == FUNC_OBSERVE) begin
      // lowest-indexed bound at or above the sample wins
      bin = OVF_BUCKET;
      for (int i = NUM_BOUNDS - 1; i >= 0; i--)
        if (smp <= bound_regs[i]) bin = i[BKT_W-1:0];
      if (bin_counts[bin] != '1) bin_counts[bin] = bin_counts[bin] + 1'b1;
      if (obs_total != '1) obs_total = obs_total + 1'b1;
      wide_sum = {1'b0, lat_sum} + (SUM_W + 1)'(smp);
      lat_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
      r.hit = bin;
    end else begin
      if (sel > OVF_BUCKET) sel = OVF_BUCKET;
      r.cnt = bin_counts[sel];
      acc = '0;
      for (int i = 0; i < NUM_BUCKETS; i++)
        if (i <= sel) begin
          acc = acc + {1'b0, bin_counts[i]};
          if (acc[DATA_W]) acc = {1'b0, {DATA_W{1'b1}}};
        end
      r.cum = acc[DATA_W-1:0];
    end
    r.tot = obs_total;
    r.sum = lat_sum;
    return r;
  endfunction

  task automatic flag_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    err_count++;
    if (err_count <= MAX_PRINT)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, fname, exp_v, act_v);
  endtask

  // result checker
  always @(posedge clk) begin
    hist_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINT)
          $display("%0t: unexpected result word: expected none, got 0x%0h",
                   $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[3:0] !== want.hit) flag_field("bucket_hit", want.hit, out_tdata[3:0]);
        if (out_tdata[35:4] !== want.cnt)
          flag_field("bucket_count", want.cnt, out_tdata[35:4]);
        if (out_tdata[67:36] !== want.cum)
          flag_field("cumulative_count", want.cum, out_tdata[67:36]);
        if (out_tdata[99:68] !== want.tot)
          flag_field("total_count", want.tot, out_tdata[99:68]);
        if (out_tdata[147:100] !== want.sum)
          flag_field("value_sum", want.sum, out_tdata[147:100]);
      end
    end
  end

  // receiver: random stall bursts, long hold-offs on request, none when quiet
  always @(posedge clk) begin
    int stall_left;
    int hold_left;
    bit hold_done;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (quiet) begin
      out_tready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 8);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // offer one word and hold it until accepted; returns on the accepting edge
  task automatic push_word(logic op, logic [DATA_W-1:0] smp, logic [BKT_W-1:0] sel);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - DATA_W - BKT_W){1'b0}}, sel, smp};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(histogram_predict(op, smp, sel));
  endtask

  task automatic sender_gap();
    if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // let every expected word arrive, then pad more cycles
  task automatic drain_block(int pad);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx < NUM_REGS) bound_regs[idx[REG_IDX_W-1:0]] = val;
    @(posedge clk);
  endtask

  task automatic observe(logic [DATA_W-1:0] smp);
    push_word(FUNC_OBSERVE, smp, BKT_W'($urandom_range(0, 15)));
    sender_gap();
  endtask

  task automatic read_bin(logic [BKT_W-1:0] sel);
    push_word(FUNC_READ, $urandom, sel);
    sender_gap();
  endtask

  // random word: samples lean toward bound edges so every bucket gets traffic
  task automatic send_random_word();
    logic [DATA_W-1:0] smp;
    logic [BKT_W-1:0]  sel;
    if ($urandom_range(0, 3) == 0) begin
      sel = ($urandom_range(0, 4) == 0) ? BKT_W'($urandom_range(9, 15))
                                        : BKT_W'($urandom_range(0, 8));
      read_bin(sel);
    end else begin
      case ($urandom_range(0, 5))
        0:       smp = $urandom;
        1:       smp = $urandom_range(0, 15);
        2:       smp = '1;
        default: smp = bound_regs[$urandom_range(0, NUM_REGS - 1)]
                       + $urandom_range(0, 4) - 2;
      endcase
      observe(smp);
    end
  endtask

  task automatic load_bounds(int style);
    logic [DATA_W-1:0] b;
    b = $urandom_range(0, 2000);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (style)
        0:       write_bound(CFG_IDX_W'(i), '0);
        1:       write_bound(CFG_IDX_W'(i), '1);
        2:       write_bound(CFG_IDX_W'(i), $urandom);
        default: begin
          write_bound(CFG_IDX_W'(i), b);
          b = b + $urandom_range(0, 1 << (2 * i + 4));
        end
      endcase
    end
  endtask

  // defaults after reset: edges of the first and last bound, reads of all kinds
  task automatic test_default_bounds();
    observe(0);
    observe(1000);
    observe(1001);
    observe(5000000);
    observe(5000001);
    observe('1);
    read_bin(0);
    read_bin(OVF_BUCKET);
    read_bin(9);
    read_bin(15);
    drain_block(PIPE_PAD);
  endtask

  // extreme bound values, plus writes above the last register that must be dropped
  task automatic test_bound_extremes();
    write_bound(0, '0);
    for (int i = 1; i < NUM_REGS - 1; i++) write_bound(CFG_IDX_W'(i), 32'd100 * i);
    write_bound(CFG_IDX_W'(NUM_REGS - 1), '1);
    write_bound(4'd8, 32'h0000_0005);
    write_bound(4'd15, 32'hA5A5_5A5A);
    observe(0);
    observe(1);
    observe('1);
    read_bin(7);
    drain_block(PIPE_PAD);
  endtask

  // descending bounds: lowest index that covers the sample takes it
  task automatic test_unsorted_bounds();
    for (int i = 0; i < NUM_REGS; i++)
      write_bound(CFG_IDX_W'(i), 32'd80000 - 32'd10000 * i);
    observe(5000);
    observe(75000);
    observe(80001);
    observe(65000);
    read_bin(3);
    drain_block(PIPE_PAD);
  endtask

  // random words across several bound settings
  task automatic test_random_traffic();
    int styles [6] = '{3, 0, 3, 1, 2, 3};
    for (int p = 0; p < 6; p++) begin
      load_bounds(styles[p]);
      gap_odds = $urandom_range(0, 4);
      repeat (50) send_random_word();
      drain_block(PIPE_PAD);
    end
  endtask

  // receiver holds off long enough that the block backs up into its input
  task automatic test_backpressure();
    hold_req = 1'b1;
    gap_odds = 0;
    repeat (40) send_random_word();
    gap_odds = 4;
    drain_block(PIPE_PAD);
  endtask

  // sender stops mid-stream until all outstanding words are back
  task automatic test_paused_sender();
    repeat (20) send_random_word();
    drain_block(0);
    repeat (20) send_random_word();
    drain_block(PIPE_PAD);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail();
    quiet = 1'b1;
    load_bounds(3);
    repeat (100) send_random_word();
    drain_block(PIPE_PAD);
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) bound_regs[i] = BOUND_RESET[i];
    for (int i = 0; i < NUM_BUCKETS; i++) bin_counts[i] = '0;
    obs_total = '0;
    lat_sum   = '0;
    repeat (RST_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_bounds();
    test_bound_extremes();
    test_unsorted_bounds();
    test_random_traffic();
    test_backpressure();
    test_paused_sender();
    test_full_rate_tail();

    if (err_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
